### src/cbhp_pkg.sv
`default_nettype none

package cbhp_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FUNC_W     = 2;
  localparam int HALF_W     = 7;
  localparam int GAIN_W     = 20;
  localparam int OUT_W      = 26;
  localparam int GAIN_FRAC  = 16;
  localparam int OUT_FRAC   = 4;
  localparam int DEN_SHIFT  = GAIN_FRAC - OUT_FRAC;
  localparam int MAX_HALF   = 2**HALF_W - 1;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [HALF_W-1:0]   HALF_RESET = 7'd90;
  localparam logic [SAMPLE_W-1:0] LEAD_RESET = 16'h8000;
  localparam logic [GAIN_W-1:0]   GAIN_RESET = 20'h10000;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  // Largest magnitude that a negative result can take without clipping.
  localparam logic [OUT_W-1:0]        NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_DRAIN  = 2'd1,
    FUNC_START  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_HALF_WINDOW   = 2'd0,
    REG_LEAD_OFF_CODE = 2'd1,
    REG_GAIN_Q16      = 2'd2
  } reg_e;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
    logic lead_off;
    logic last;
  } div_side_t;

endpackage

`default_nettype wire

### src/cbhp_stream_if.sv
`default_nettype none

interface cbhp_in_if import cbhp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);
endinterface

interface cbhp_out_if import cbhp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered;
  logic                    lead_off;
  logic                    last;

  modport source (output valid, output filtered, output lead_off, output last, input ready);
  modport sink   (input valid, input filtered, input lead_off, input last, output ready);
endinterface

`default_nettype wire

### src/centered_boxcar_highpass.sv
`default_nettype none
// A word with a result passes the trim, subtract (when the oldest sample leaves the
// window), multiply, numerator, gain and divide states and the 26-cell divider chain,
// which sets most of the delay. A word with no result keeps the block in idle; a word
// with a result blocks input until its result enters the output register, and longer
// while the previous result is not yet taken. Input is taken again while a finished
// result still waits in the output register. Reset clears control state and loads the
// register reset values, not the sample ring: an entry is always written before it is read.

module centered_boxcar_highpass import cbhp_pkg::*; #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cbhp_in_if.sink               in_i,
  cbhp_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int PTR1_W = PTR_W + 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int PEND_W = $clog2(MAX_WINDOW / 2 + 1);
  localparam int CMP_W  = CNT_W + 1;
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int NUM_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + GAIN_W;
  localparam int RND_W  = PROD_W + 1;
  localparam int DVD_W  = RND_W - DEN_SHIFT;
  localparam int HI_W   = DVD_W - OUT_W;
  localparam int RING_W = SAMPLE_W + 1;
  localparam int HalfLim = (MAX_WINDOW - 2) / 2;
  localparam logic [HALF_W-1:0] HalfCap =
    (HalfLim > MAX_HALF) ? HALF_W'(MAX_HALF) : HALF_W'(HalfLim);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIM,
    ST_SUB,
    ST_MUL,
    ST_NUM,
    ST_GAIN,
    ST_DIV,
    ST_WAIT,
    ST_OUT
  } state_e;

  function automatic logic [PTR_W-1:0] back_idx(input logic [PTR_W-1:0] wp,
                                                input logic [CNT_W-1:0] k);
    logic [PTR1_W-1:0] kk;
    logic [PTR1_W-1:0] t;
    kk = (k == CNT_W'(MAX_WINDOW)) ? '0 : PTR1_W'(k);
    t  = {1'b0, wp} + PTR1_W'(MAX_WINDOW) - kk;
    if (t >= PTR1_W'(MAX_WINDOW)) begin
      t = t - PTR1_W'(MAX_WINDOW);
    end
    return t[PTR_W-1:0];
  endfunction

  // Control registers
  state_e                    state_q, state_d;
  logic [HALF_W-1:0]         half_q, half_d;
  logic [SAMPLE_W-1:0]       lead_q, lead_d;
  logic [GAIN_W-1:0]         gain_q, gain_d;
  logic [PTR_W-1:0]          wp_q, wp_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [PEND_W-1:0]         pend_q, pend_d;
  logic                      started_q, started_d;
  logic [HALF_W-1:0]         act_half_q, act_half_d;
  logic                      out_valid_q, out_valid_d;

  // Datapath registers
  logic                      last_q, last_d;
  logic signed [SUM_W-1:0]   xc_q, xc_d;
  logic                      flag_q, flag_d;
  logic                      zero_q, zero_d;
  logic                      neg_q, neg_d;
  logic [SUM_W-1:0]          mag_q, mag_d;
  logic [PROD_W-1:0]         prod_q, prod_d;
  logic signed [OUT_W-1:0]   res_q, res_d;
  logic                      res_lo_q, res_lo_d;
  logic                      res_last_q, res_last_d;
  logic signed [OUT_W-1:0]   out_filt_q, out_filt_d;
  logic                      out_lo_q, out_lo_d;
  logic                      out_last_q, out_last_d;

  // Ring memory
  logic                      ram_we;
  logic [PTR_W-1:0]          ram_raddr;
  logic [RING_W-1:0]         ram_wdata;
  logic [RING_W-1:0]         ram_rdata;

  // Divider chain
  logic                      div_in_valid;
  div_side_t                 div_in_side;
  logic                      div_out_valid;
  div_side_t                 div_out_side;
  logic [OUT_W-1:0]          div_quo;

  logic                      in_fire;
  logic                      cfg_write;
  logic [1:0]                cfg_idx;
  logic signed [SAMPLE_W-1:0] smp_v;
  logic                      smp_lo;
  logic [HALF_W-1:0]         half_clamped;
  logic [HALF_W-1:0]         h_now;
  logic [PEND_W-1:0]         pend_inc;
  logic [PTR_W-1:0]          wp_next;
  logic                      trim;
  logic signed [SAMPLE_W-1:0] x_s;
  logic signed [SUM_W-1:0]   x_ext;
  logic signed [SUM_W-1:0]   cnt_ext;
  logic signed [NUM_W-1:0]   num;
  logic signed [NUM_W-1:0]   num_neg;
  logic [RND_W-1:0]          rnd;
  logic [DVD_W-1:0]          dvd_all;
  logic [HI_W-1:0]           dvd_hi;
  logic                      ovf;
  logic signed [OUT_W-1:0]   final_val;

  assign in_fire   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[3:2];

  assign smp_lo       = (in_i.sample == lead_q);
  assign smp_v        = smp_lo ? '0 : in_i.sample;
  assign half_clamped = (half_q > HalfCap) ? HalfCap : half_q;
  assign h_now        = started_q ? act_half_q : half_clamped;
  assign pend_inc     = pend_q + 1'b1;
  assign wp_next      = (wp_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
  assign trim = CMP_W'(cnt_q) > (CMP_W'(pend_q) + CMP_W'(act_half_q));

  assign ram_wdata = {smp_lo, smp_v};
  assign x_s       = $signed(ram_rdata[SAMPLE_W-1:0]);
  assign x_ext     = SUM_W'(x_s);
  assign cnt_ext   = $signed(SUM_W'(cnt_q));

  assign num     = NUM_W'(xc_q) - NUM_W'(sum_q);
  assign num_neg = -num;

  // Rounding offset is half the divisor, count times 2048.
  assign rnd     = RND_W'(prod_q) + RND_W'({cnt_q, {(DEN_SHIFT-1){1'b0}}});
  assign dvd_all = rnd[RND_W-1:DEN_SHIFT];
  assign dvd_hi  = dvd_all[DVD_W-1:OUT_W];
  assign ovf     = CNT_W'(dvd_hi) >= cnt_q;

  always_comb begin
    if (div_out_side.zero) begin
      final_val = '0;
    end else if (div_out_side.neg) begin
      final_val = (div_out_side.ovf || div_quo > NEG_LIM) ? OUT_MIN
                                                           : $signed(~div_quo + 1'b1);
    end else begin
      final_val = (div_out_side.ovf || div_quo[OUT_W-1]) ? OUT_MAX : $signed(div_quo);
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_e'(cfg_idx))
      REG_HALF_WINDOW:   prdata = APB_DATA_W'(half_q);
      REG_LEAD_OFF_CODE: prdata = APB_DATA_W'(lead_q);
      REG_GAIN_Q16:      prdata = APB_DATA_W'(gain_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    half_d      = half_q;
    lead_d      = lead_q;
    gain_d      = gain_q;
    wp_d        = wp_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    pend_d      = pend_q;
    started_d   = started_q;
    act_half_d  = act_half_q;
    out_valid_d = out_valid_q && !out_o.ready;
    last_d      = last_q;
    xc_d        = xc_q;
    flag_d      = flag_q;
    zero_d      = zero_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    res_d       = res_q;
    res_lo_d    = res_lo_q;
    res_last_d  = res_last_q;
    out_filt_d  = out_filt_q;
    out_lo_d    = out_lo_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_raddr   = back_idx(wp_q, CNT_W'(pend_q));
    div_in_valid = 1'b0;
    div_in_side  = '{neg: neg_q, zero: zero_q, ovf: ovf, lead_off: flag_q, last: last_q};

    if (cfg_write) begin
      unique case (reg_e'(cfg_idx))
        REG_HALF_WINDOW:   half_d = pwdata[HALF_W-1:0];
        REG_LEAD_OFF_CODE: lead_d = pwdata[SAMPLE_W-1:0];
        REG_GAIN_Q16:      gain_d = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (func_e'(in_i.func))
            FUNC_SAMPLE: begin
              ram_we     = 1'b1;
              wp_d       = wp_next;
              cnt_d      = cnt_q + 1'b1;
              sum_d      = sum_q + SUM_W'(smp_v);
              pend_d     = pend_inc;
              started_d  = 1'b1;
              act_half_d = h_now;
              last_d     = 1'b0;
              if (CMP_W'(pend_inc) > CMP_W'(h_now)) begin
                state_d = ST_TRIM;
              end
            end
            FUNC_DRAIN: begin
              if (pend_q != '0) begin
                last_d  = (pend_q == PEND_W'(1));
                state_d = ST_TRIM;
              end
            end
            FUNC_START: begin
              wp_d      = '0;
              cnt_d     = '0;
              sum_d     = '0;
              pend_d    = '0;
              started_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Drop the oldest sample when the window reaches past its trailing edge.
      ST_TRIM: begin
        if (trim) begin
          ram_raddr = back_idx(wp_q, cnt_q);
          state_d   = ST_SUB;
        end else begin
          state_d   = ST_MUL;
        end
      end
      ST_SUB: begin
        sum_d   = sum_q - SUM_W'(x_s);
        cnt_d   = cnt_q - 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        xc_d    = x_ext * cnt_ext;
        flag_d  = ram_rdata[SAMPLE_W];
        zero_d  = ram_rdata[SAMPLE_W] || (cnt_q == '0);
        pend_d  = pend_q - 1'b1;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        neg_d   = num[NUM_W-1];
        mag_d   = num[NUM_W-1] ? num_neg[SUM_W-1:0] : num[SUM_W-1:0];
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        prod_d  = PROD_W'(mag_q) * PROD_W'(gain_q);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        div_in_valid = 1'b1;
        state_d      = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_out_valid) begin
          res_d      = final_val;
          res_lo_d   = div_out_side.lead_off;
          res_last_d = div_out_side.last;
          state_d    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_filt_d  = res_q;
          out_lo_d    = res_lo_q;
          out_last_d  = res_last_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= HALF_RESET;
      lead_q      <= LEAD_RESET;
      gain_q      <= GAIN_RESET;
      wp_q        <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      pend_q      <= '0;
      started_q   <= 1'b0;
      act_half_q  <= HALF_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      half_q      <= half_d;
      lead_q      <= lead_d;
      gain_q      <= gain_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      pend_q      <= pend_d;
      started_q   <= started_d;
      act_half_q  <= act_half_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    xc_q       <= xc_d;
    flag_q     <= flag_d;
    zero_q     <= zero_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    prod_q     <= prod_d;
    res_q      <= res_d;
    res_lo_q   <= res_lo_d;
    res_last_q <= res_last_d;
    out_filt_q <= out_filt_d;
    out_lo_q   <= out_lo_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.filtered = out_filt_q;
  assign out_o.lead_off = out_lo_q;
  assign out_o.last     = out_last_q;

  cbhp_ram #(
    .WIDTH(RING_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  cbhp_div_chain #(
    .CW(CNT_W),
    .QW(OUT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(div_in_valid),
    .side_i (div_in_side),
    .dvd_i  (dvd_all[OUT_W-1:0]),
    .rem_i  (ovf ? '0 : CNT_W'(dvd_hi)),
    .dvs_i  (cnt_q),
    .valid_o(div_out_valid),
    .side_o (div_out_side),
    .quo_o  (div_quo)
  );

endmodule

`default_nettype wire

### src/cbhp_ram.sv
`default_nettype none

module cbhp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/cbhp_div_cell.sv
`default_nettype none

module cbhp_div_cell import cbhp_pkg::*; #(
  parameter int CW = 9,
  parameter int QW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  div_side_t     side_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [CW-1:0] rem_i,
  input  logic [CW-1:0] dvs_i,
  input  logic [QW-1:0] quo_i,
  output logic          valid_o,
  output div_side_t     side_o,
  output logic [QW-1:0] dvd_o,
  output logic [CW-1:0] rem_o,
  output logic [CW-1:0] dvs_o,
  output logic [QW-1:0] quo_o
);

  logic          valid_q;
  div_side_t     side_q;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [CW-1:0] rem_q, rem_d;
  logic [CW-1:0] dvs_q;
  logic [QW-1:0] quo_q, quo_d;

  logic [CW:0] trial;
  logic [CW:0] diff;
  logic        fits;

  // One restoring step: bring down the next dividend bit and subtract if it fits.
  assign trial = {rem_i, dvd_i[QW-1]};
  assign fits  = trial >= {1'b0, dvs_i};
  assign diff  = trial - {1'b0, dvs_i};
  assign rem_d = fits ? diff[CW-1:0] : trial[CW-1:0];
  assign dvd_d = {dvd_i[QW-2:0], 1'b0};
  assign quo_d = {quo_i[QW-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_i;
    quo_q  <= quo_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign dvd_o   = dvd_q;
  assign rem_o   = rem_q;
  assign dvs_o   = dvs_q;
  assign quo_o   = quo_q;

endmodule

`default_nettype wire

### src/cbhp_div_chain.sv
`default_nettype none

module cbhp_div_chain import cbhp_pkg::*; #(
  parameter int CW = 9,
  parameter int QW = 26
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  div_side_t     side_i,
  input  logic [QW-1:0] dvd_i,
  input  logic [CW-1:0] rem_i,
  input  logic [CW-1:0] dvs_i,
  output logic          valid_o,
  output div_side_t     side_o,
  output logic [QW-1:0] quo_o
);

  logic          valid_s [QW+1];
  div_side_t     side_s  [QW+1];
  logic [QW-1:0] dvd_s   [QW+1];
  logic [CW-1:0] rem_s   [QW+1];
  logic [CW-1:0] dvs_s   [QW+1];
  logic [QW-1:0] quo_s   [QW+1];

  assign valid_s[0] = valid_i;
  assign side_s[0]  = side_i;
  assign dvd_s[0]   = dvd_i;
  assign rem_s[0]   = rem_i;
  assign dvs_s[0]   = dvs_i;
  assign quo_s[0]   = '0;

  // Each cell yields one quotient bit, most significant first.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    cbhp_div_cell #(
      .CW(CW),
      .QW(QW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[i]),
      .side_i (side_s[i]),
      .dvd_i  (dvd_s[i]),
      .rem_i  (rem_s[i]),
      .dvs_i  (dvs_s[i]),
      .quo_i  (quo_s[i]),
      .valid_o(valid_s[i+1]),
      .side_o (side_s[i+1]),
      .dvd_o  (dvd_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .dvs_o  (dvs_s[i+1]),
      .quo_o  (quo_s[i+1])
    );
  end

  assign valid_o = valid_s[QW];
  assign side_o  = side_s[QW];
  assign quo_o   = quo_s[QW];

endmodule

`default_nettype wire
